FILE: hw/rtl/cvf_pkg.sv
// Shared types, constants and helpers of the 3x3 convolution filter.
`default_nettype none

package cvf_pkg;

	localparam int unsigned MAX_WIDTH_DEF  = 2048;
	localparam int unsigned CHANNELS_DEF   = 3;
	localparam int unsigned COEF_FRAC_BITS = 12;

	localparam int unsigned SAMPLE_BITS    = 8;
	localparam int unsigned WIDTH_BITS     = 12;
	localparam int unsigned HEIGHT_BITS    = 13;
	localparam int unsigned KROW_BITS      = 48;
	localparam int unsigned COEF_BITS      = 16;
	localparam int unsigned PROD_BITS      = SAMPLE_BITS + 1 + COEF_BITS;
	localparam int unsigned SUM_BITS       = PROD_BITS + 4;
	localparam int unsigned TAP_COUNT      = 9;
	localparam int unsigned CFG_INDEX_BITS = 3;

	// Register indexes on the configuration channel.
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_TOP    = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_MIDDLE = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KERNEL_BOTTOM = 3'd4;

	// Identity kernel: centre coefficient 1.0 in Q4.12.
	localparam logic [KROW_BITS-1:0] KERNEL_MIDDLE_RESET = 48'h0000_1000_0000;

	localparam logic signed [SUM_BITS-1:0] ROUND_HALF =
		SUM_BITS'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [SUM_BITS-1:0] SAT_MAX = SUM_BITS'(255);

	typedef logic [SAMPLE_BITS-1:0]      pix_t;
	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic [KROW_BITS-1:0]        krow_t;
	typedef logic signed [PROD_BITS-1:0] prod_t;

	typedef struct packed {
		krow_t top;
		krow_t middle;
		krow_t bottom;
	} kernel_t;

	// Where the value of a result word comes from.
	typedef enum logic [1:0] {
		SRC_FILTER,
		SRC_PASS,
		SRC_UPPER,
		SRC_MIDDLE
	} src_t;

	// Control of one item entering the line store stage.
	typedef struct packed {
		logic wr;
		logic res;
		src_t src;
		logic last;
	} cvf_ctl_t;

	// Control of one result word in the multiply stage.
	typedef struct packed {
		logic filt;
		pix_t value;
		logic last;
	} cvf_s2_t;

	function automatic coef_t coef_of(kernel_t k, int r, int c);
		krow_t row;
		row = (r == 0) ? k.top : ((r == 1) ? k.middle : k.bottom);
		return row[COEF_BITS*c +: COEF_BITS];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cvf_if.sv
// Channel interfaces of the 3x3 convolution filter: samples, results, configuration.
`default_nettype none

interface cvf_in_if;
	import cvf_pkg::*;
	logic valid;
	logic ready;
	logic action;
	pix_t sample;
	modport source (output valid, output action, output sample, input ready);
	modport sink (input valid, input action, input sample, output ready);
endinterface

interface cvf_out_if;
	import cvf_pkg::*;
	logic valid;
	logic ready;
	pix_t filtered_sample;
	logic frame_last;
	modport source (output valid, output filtered_sample, output frame_last, input ready);
	modport sink (input valid, input filtered_sample, input frame_last, output ready);
endinterface

interface cvf_cfg_if;
	import cvf_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [KROW_BITS-1:0]      data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/conv3x3_line_buffer_filter.sv
// 3x3 convolution filter over an interleaved raster stream: top level.
//
// Usage: write image_width, image_height and the three kernel rows on cfg while
// the block is idle; cfg.ready is always high. Then stream the samples of a
// frame on samples (action 0), one channel value per word in raster order.
// Results come out on results in raster order, one row plus one pixel
// (width*CHANNELS + CHANNELS words) behind the input; after the last sample,
// drain words (action 1) push out the remaining results, and the word with
// frame_last high ends the frame.
// Throughput is one word per clock cycle while results does not stall: each
// word does one read and one write in each of the two line stores, whose
// separate ports allow that. A result passes the store stage and the product
// stage before it reaches the output register.
// When results stalls, the store stage, the product stage and the output
// register hold up to three words before samples.ready drops.
// Reset sets width and height to zero (every word is then ignored), loads the
// identity kernel and clears the counters and taps; the line stores are not
// cleared, which needs no wait after reset.
`default_nettype none

module conv3x3_line_buffer_filter #(
	parameter int unsigned MAX_WIDTH = cvf_pkg::MAX_WIDTH_DEF,
	parameter int unsigned CHANNELS  = cvf_pkg::CHANNELS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	cvf_in_if.sink     samples,
	cvf_out_if.source  results,
	cvf_cfg_if.sink    cfg
);
	import cvf_pkg::*;

	localparam int unsigned DEPTH = MAX_WIDTH * CHANNELS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic           s1_free, enter, we, o_free, valid_s2;
	cvf_ctl_t       ctl;
	logic [AW-1:0]  idx, waddr;
	logic [CHW-1:0] ch_in, ch_out;
	pix_t           sample, up_rd, mid_rd, up_wdata, mid_wdata;
	kernel_t        kernel;
	cvf_s2_t        ctl_s2;
	prod_t          prod_s2 [TAP_COUNT];

	cvf_ctrl #(
		.MAX_WIDTH (MAX_WIDTH),
		.CHANNELS  (CHANNELS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.cfg     (cfg),
		.s1_free (s1_free),
		.enter   (enter),
		.ctl     (ctl),
		.idx     (idx),
		.ch_in   (ch_in),
		.ch_out  (ch_out),
		.sample  (sample),
		.kernel  (kernel)
	);

	cvf_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_upper_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (up_wdata),
		.re    (enter),
		.raddr (idx),
		.rdata (up_rd)
	);

	cvf_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_middle_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (mid_wdata),
		.re    (enter),
		.raddr (idx),
		.rdata (mid_rd)
	);

	cvf_window #(
		.MAX_WIDTH (MAX_WIDTH),
		.CHANNELS  (CHANNELS)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.enter     (enter),
		.ctl       (ctl),
		.idx       (idx),
		.ch_in     (ch_in),
		.ch_out    (ch_out),
		.sample    (sample),
		.kernel    (kernel),
		.up_rd     (up_rd),
		.mid_rd    (mid_rd),
		.o_free    (o_free),
		.s1_free   (s1_free),
		.we        (we),
		.waddr     (waddr),
		.up_wdata  (up_wdata),
		.mid_wdata (mid_wdata),
		.valid_s2  (valid_s2),
		.ctl_s2    (ctl_s2),
		.prod_s2   (prod_s2)
	);

	cvf_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.ctl_s2   (ctl_s2),
		.prod_s2  (prod_s2),
		.o_free   (o_free),
		.results  (results)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/cvf_ram.sv
// Generic simple dual-port RAM with registered read (old data on a same-address write).
`default_nettype none

module cvf_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cvf_ctrl.sv
// Configuration registers and raster sequencing of the 3x3 convolution filter.
`default_nettype none

module cvf_ctrl #(
	parameter int unsigned MAX_WIDTH = cvf_pkg::MAX_WIDTH_DEF,
	parameter int unsigned CHANNELS  = cvf_pkg::CHANNELS_DEF,
	localparam int unsigned AW  = $clog2(MAX_WIDTH * CHANNELS),
	localparam int unsigned CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	cvf_in_if.sink              samples,
	cvf_cfg_if.sink             cfg,
	input  wire logic           s1_free,
	output logic                enter,
	output cvf_pkg::cvf_ctl_t   ctl,
	output logic [AW-1:0]       idx,
	output logic [CHW-1:0]      ch_in,
	output logic [CHW-1:0]      ch_out,
	output cvf_pkg::pix_t       sample,
	output cvf_pkg::kernel_t    kernel
);
	import cvf_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned RW = HEIGHT_BITS;
	localparam int unsigned PW = $clog2(MAX_WIDTH * CHANNELS + CHANNELS + 2);

	logic [WIDTH_BITS-1:0] image_width_q;
	logic [RW-1:0]         image_height_q;
	kernel_t               kernel_q;

	logic [CW-1:0]  col_q, ocol_q;
	logic [RW-1:0]  row_q, orow_q;
	logic [CHW-1:0] chan_q, ochan_q;
	logic [PW-1:0]  pend_q;

	logic [CW-1:0]  c_col, c_ocol, col_d, ocol_d;
	logic [RW-1:0]  c_row, c_orow, row_d, orow_d;
	logic [CHW-1:0] c_chan, c_ochan, chan_d, ochan_d;
	logic [PW-1:0]  c_pend, pend_d, pend_inc, lag;

	logic [WW-1:0] w;
	logic [RW-1:0] h;
	logic accept, active, frame_restart, in_phase, is_sample, is_drain;
	logic emit, last, interior;
	logic chan_wrap, col_wrap, ochan_wrap, ocol_wrap;
	logic [AW-1:0] in_idx, out_idx;

	assign samples.ready = s1_free;
	assign cfg.ready     = 1'b1;
	assign accept        = samples.valid && samples.ready;
	assign kernel        = kernel_q;
	assign sample        = samples.sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= '0;
			image_height_q  <= '0;
			kernel_q.top    <= '0;
			kernel_q.middle <= KERNEL_MIDDLE_RESET;
			kernel_q.bottom <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH:   image_width_q   <= cfg.data[WIDTH_BITS-1:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= cfg.data[RW-1:0];
				REG_KERNEL_TOP:    kernel_q.top    <= cfg.data;
				REG_KERNEL_MIDDLE: kernel_q.middle <= cfg.data;
				REG_KERNEL_BOTTOM: kernel_q.bottom <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (32'(image_width_q) > MAX_WIDTH) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(image_width_q);
		end
		h = image_height_q;
	end

	assign active = (w != '0) && (h != '0);
	// A fully accepted frame with nothing left to deliver starts over at zero.
	assign frame_restart = (row_q >= h) && (pend_q == '0);

	always_comb begin
		c_col   = frame_restart ? '0 : col_q;
		c_row   = frame_restart ? '0 : row_q;
		c_chan  = frame_restart ? '0 : chan_q;
		c_pend  = frame_restart ? '0 : pend_q;
		c_ocol  = frame_restart ? '0 : ocol_q;
		c_orow  = frame_restart ? '0 : orow_q;
		c_ochan = frame_restart ? '0 : ochan_q;

		in_phase  = c_row < h;
		is_sample = in_phase && !samples.action;
		is_drain  = !in_phase;

		lag      = PW'((32'(w) + 32'd1) * CHANNELS);
		pend_inc = c_pend + PW'(1);

		chan_wrap  = (32'(c_chan) + 32'd1) >= CHANNELS;
		col_wrap   = (32'(c_col) + 32'd1) >= 32'(w);
		ochan_wrap = (32'(c_ochan) + 32'd1) >= CHANNELS;
		ocol_wrap  = (32'(c_ocol) + 32'd1) >= 32'(w);

		last = ((32'(c_orow) + 32'd1) >= 32'(h)) && ocol_wrap && ochan_wrap;
		interior = (32'(w) >= 32'd3) && (32'(h) >= 32'd3) &&
		           (c_orow != '0) && ((32'(c_orow) + 32'd1) < 32'(h)) &&
		           (c_ocol != '0) && ocol_wrap == 1'b0;

		emit = is_drain || (is_sample && (pend_inc > lag));

		in_idx  = AW'(32'(c_col) * CHANNELS + 32'(c_chan));
		out_idx = AW'(32'(c_ocol) * CHANNELS + 32'(c_ochan));

		col_d   = c_col;
		row_d   = c_row;
		chan_d  = c_chan;
		ocol_d  = c_ocol;
		orow_d  = c_orow;
		ochan_d = c_ochan;
		pend_d  = c_pend;

		if (is_sample) begin
			chan_d = chan_wrap ? '0 : c_chan + CHW'(1);
			if (chan_wrap) begin
				col_d = col_wrap ? '0 : c_col + CW'(1);
				if (col_wrap) begin
					row_d = c_row + RW'(1);
				end
			end
			pend_d = emit ? c_pend : pend_inc;
		end else if (is_drain) begin
			pend_d = c_pend - PW'(1);
		end

		if (emit) begin
			if (last) begin
				col_d   = '0;
				row_d   = '0;
				chan_d  = '0;
				ocol_d  = '0;
				orow_d  = '0;
				ochan_d = '0;
				pend_d  = '0;
			end else begin
				ochan_d = ochan_wrap ? '0 : c_ochan + CHW'(1);
				if (ochan_wrap) begin
					ocol_d = ocol_wrap ? '0 : c_ocol + CW'(1);
					if (ocol_wrap) begin
						orow_d = c_orow + RW'(1);
					end
				end
			end
		end

		enter    = accept && active && (is_sample || is_drain);
		ctl.wr   = is_sample;
		ctl.res  = emit;
		ctl.last = last;
		if (is_drain) begin
			ctl.src = ((32'(c_orow) + 32'd1) >= 32'(h)) ? SRC_MIDDLE : SRC_UPPER;
		end else begin
			ctl.src = interior ? SRC_FILTER : SRC_PASS;
		end
		idx    = is_drain ? out_idx : in_idx;
		ch_in  = c_chan;
		ch_out = c_ochan;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			chan_q  <= '0;
			pend_q  <= '0;
			ocol_q  <= '0;
			orow_q  <= '0;
			ochan_q <= '0;
		end else if (accept && active) begin
			col_q   <= col_d;
			row_q   <= row_d;
			chan_q  <= chan_d;
			pend_q  <= pend_d;
			ocol_q  <= ocol_d;
			orow_q  <= orow_d;
			ochan_q <= ochan_d;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cvf_window.sv
// Line store write-back, 3x3 tap windows and coefficient products of the filter.
`default_nettype none

module cvf_window #(
	parameter int unsigned MAX_WIDTH = cvf_pkg::MAX_WIDTH_DEF,
	parameter int unsigned CHANNELS  = cvf_pkg::CHANNELS_DEF,
	localparam int unsigned AW  = $clog2(MAX_WIDTH * CHANNELS),
	localparam int unsigned CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              enter,
	input  wire cvf_pkg::cvf_ctl_t ctl,
	input  wire logic [AW-1:0]     idx,
	input  wire logic [CHW-1:0]    ch_in,
	input  wire logic [CHW-1:0]    ch_out,
	input  wire cvf_pkg::pix_t     sample,
	input  wire cvf_pkg::kernel_t  kernel,
	input  wire cvf_pkg::pix_t     up_rd,
	input  wire cvf_pkg::pix_t     mid_rd,
	input  wire logic              o_free,
	output logic                   s1_free,
	output logic                   we,
	output logic [AW-1:0]          waddr,
	output cvf_pkg::pix_t          up_wdata,
	output cvf_pkg::pix_t          mid_wdata,
	output logic                   valid_s2,
	output cvf_pkg::cvf_s2_t       ctl_s2,
	output cvf_pkg::prod_t         prod_s2 [cvf_pkg::TAP_COUNT]
);
	import cvf_pkg::*;

	logic           valid_s1;
	cvf_ctl_t       ctl_s1;
	logic [AW-1:0]  idx_s1;
	logic [CHW-1:0] ch_in_s1, ch_out_s1;
	pix_t           sample_s1;
	logic           hit_s1;
	pix_t           fwd_up_s1, fwd_mid_s1;

	pix_t taps_q [CHANNELS][3][3];  // [channel][column][row]

	pix_t  up_col, mid_col;
	pix_t  newcol [3];
	pix_t  win [3][3];              // [column][row]
	prod_t prod [TAP_COUNT];
	pix_t  direct;
	logic  adv_s1, s2_free, same;

	// The store read of an item races the write of the item ahead of it;
	// when both hit one address, the written values are taken instead.
	assign up_col  = hit_s1 ? fwd_up_s1 : up_rd;
	assign mid_col = hit_s1 ? fwd_mid_s1 : mid_rd;

	assign s2_free = !valid_s2 || o_free;
	assign adv_s1  = valid_s1 && (!ctl_s1.res || s2_free);
	assign s1_free = !valid_s1 || adv_s1;

	assign we        = adv_s1 && ctl_s1.wr;
	assign waddr     = idx_s1;
	assign up_wdata  = mid_col;
	assign mid_wdata = sample_s1;

	always_comb begin
		newcol[0] = up_col;
		newcol[1] = mid_col;
		newcol[2] = sample_s1;
		// The window of the output channel, as it stands after this item's shift.
		same = (ch_in_s1 == ch_out_s1) && ctl_s1.wr;
		for (int r = 0; r < 3; r++) begin
			win[0][r] = same ? taps_q[ch_out_s1][1][r] : taps_q[ch_out_s1][0][r];
			win[1][r] = same ? taps_q[ch_out_s1][2][r] : taps_q[ch_out_s1][1][r];
			win[2][r] = same ? newcol[r] : taps_q[ch_out_s1][2][r];
		end
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				prod[r*3 + k] = $signed({1'b0, win[k][r]}) * coef_of(kernel, r, k);
			end
		end
		case (ctl_s1.src) inside
			SRC_FILTER, SRC_PASS: direct = win[1][1];
			SRC_UPPER:            direct = up_col;
			SRC_MIDDLE:           direct = mid_col;
			default:              direct = win[1][1];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (enter) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (enter) begin
			ctl_s1     <= ctl;
			idx_s1     <= idx;
			ch_in_s1   <= ch_in;
			ch_out_s1  <= ch_out;
			sample_s1  <= sample;
			hit_s1     <= we && (idx_s1 == idx);
			fwd_up_s1  <= mid_col;
			fwd_mid_s1 <= sample_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= '{default: '{default: '{default: '0}}};
		end else if (we) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (CHW'(c) == ch_in_s1) begin
					taps_q[c][0]    <= taps_q[c][1];
					taps_q[c][1]    <= taps_q[c][2];
					taps_q[c][2][0] <= up_col;
					taps_q[c][2][1] <= mid_col;
					taps_q[c][2][2] <= sample_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1 && ctl_s1.res) begin
			valid_s2 <= 1'b1;
		end else if (o_free) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ctl_s1.res) begin
			ctl_s2.filt  <= (ctl_s1.src == SRC_FILTER);
			ctl_s2.value <= direct;
			ctl_s2.last  <= ctl_s1.last;
			prod_s2      <= prod;
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/cvf_mac.sv
// Product sum, rounding, clamping and output register of the filter.
`default_nettype none

module cvf_mac (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             valid_s2,
	input  wire cvf_pkg::cvf_s2_t ctl_s2,
	input  wire cvf_pkg::prod_t   prod_s2 [cvf_pkg::TAP_COUNT],
	output logic                  o_free,
	cvf_out_if.source             results
);
	import cvf_pkg::*;

	logic signed [SUM_BITS-1:0] sum, rounded, scaled;
	pix_t filtered, value;
	logic valid_q, last_q;
	pix_t data_q;

	always_comb begin
		sum = '0;
		for (int i = 0; i < TAP_COUNT; i++) begin
			sum = sum + SUM_BITS'(prod_s2[i]);
		end
		rounded = sum + ROUND_HALF;
		scaled  = rounded >>> COEF_FRAC_BITS;
		if (sum < 0) begin
			filtered = '0;
		end else if (scaled > SAT_MAX) begin
			filtered = 8'hFF;
		end else begin
			filtered = scaled[SAMPLE_BITS-1:0];
		end
		value = ctl_s2.filt ? filtered : ctl_s2.value;
	end

	assign o_free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (valid_s2 && o_free) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && o_free) begin
			data_q <= value;
			last_q <= ctl_s2.last;
		end
	end

	assign results.valid           = valid_q;
	assign results.filtered_sample = data_q;
	assign results.frame_last      = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cvf_checker.sv
// Port-level checker of the 3x3 convolution filter and its bind to the top level.
`default_nettype none

module cvf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_data,
	input wire logic       out_last
);

	// A result word waits until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data) && $stable(out_last))
		else $error("result word changed while stalled");

	// With the output register empty the whole pipeline can move.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("samples not ready with empty output register");

	// Nothing is offered while reset is held.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result offered during reset");

endmodule

bind conv3x3_line_buffer_filter cvf_checker u_cvf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (samples.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  (results.filtered_sample),
	.out_last  (results.frame_last)
);

`default_nettype wire
